// File: sv/sha256_pkg.sv
// Shared types, constants and the round constant table for the SHA-256 stream hasher.
`default_nettype none
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;   // element 0 is a (or H0), element 7 is h (or H7)

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [6:0] LENGTH_POS  = 7'd56;
  localparam logic [7:0] PAD_BYTE    = 8'h80;

  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    begin
      case (t)
        6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
        6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
        6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
        6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
        6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
        6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
        6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
        6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
        6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
        6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
        6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
        6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
        6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
        6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
        6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
        6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
        6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
        6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
        6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
        6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
        6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
        6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
        6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
        default: k = 32'h0;
      endcase
      return k;
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/sha256_if.sv
// Valid/ready channel interfaces for message bytes in and digest words out.
`default_nettype none
interface sha256_msg_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] message_byte;

  modport source (output valid, output op, output message_byte, input ready);
  modport sink   (input valid, input op, input message_byte, output ready);
endinterface

interface sha256_digest_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  logic        length_overflow;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, output length_overflow, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, input length_overflow, output ready);
endinterface
`default_nettype wire

// File: sv/sha256_stream_hasher_core.sv
// Top level of the SHA-256 stream hasher: byte intake, padding sequencer and round engine.
`default_nettype none
// Usage. Bytes arrive on the msg channel (valid/ready, accepted when both are high).
// op = absorb adds message_byte to the current 64-byte block; op = finish pads the
// message and hashes it. Each finish yields eight words on the digest channel,
// word_index 0 (most significant) first, last_word on index 7 and length_overflow
// set on all eight if the bit count wrapped past 2^64-1.
// Sequence. The byte that completes a block starts the compression, which runs all 64
// rounds on a single round unit and then folds the result into the chaining hash.
// A finish shifts in the padding one byte a cycle (up to 64 bytes for a block of
// padding alone), starts each compression, runs one or two compressions and then
// offers the eight digest words, one a cycle while the receiver takes them.
// Sustained intake is limited by the round unit, since no byte is taken while it runs.
// msg.ready is high only while the block is idle; it stays low through compression,
// padding and digest output. If the receiver stalls, the current digest word is held
// and nothing else moves. After the eighth word is taken the chaining hash, byte count
// and overflow flag return to their initial values for the next message.
// Reset (rst, synchronous, active high) loads the initial hash, clears the counts and
// leaves the block idle and ready; no clearing pass is needed.
module sha256_stream_hasher_core (
  input  wire logic clk,
  input  wire logic rst,
  sha256_msg_if.sink      msg,
  sha256_digest_if.source digest
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {IDLE, PAD, COMP, FOLD, EMIT} state_t;

  state_t      state;
  hash_t       chain;
  hash_t       work;
  word_t       blk [16];     // block shift line, blk[0] is the oldest word
  logic [6:0]  fill;
  logic [63:0] bits;
  logic        ovf;
  logic        finishing;    // padding of the current message is under way
  logic        len_block;    // the block being padded carries the length field
  logic [5:0]  rnd;
  logic [2:0]  idx;

  hash_t       work_next;
  word_t       w_new;
  logic [64:0] bits_sum;
  logic [63:0] len_shift;
  logic [7:0]  pad_byte;

  sha256_round u_round (
    .work_in (work),
    .k       (round_k(rnd)),
    .w0      (blk[0]),
    .w1      (blk[1]),
    .w9      (blk[9]),
    .w14     (blk[14]),
    .work_out(work_next),
    .w_new   (w_new)
  );

  always_comb begin
    bits_sum  = {1'b0, bits} + 65'd8;
    // Length bytes go out big-endian: byte i of the field is bits[63-8i -: 8].
    len_shift = bits >> {~fill[2:0], 3'b000};
    pad_byte  = (len_block && (fill >= LENGTH_POS)) ? len_shift[7:0] : 8'h00;
  end

  assign msg.ready              = (state == IDLE);
  assign digest.valid           = (state == EMIT);
  assign digest.digest_word     = chain[idx];
  assign digest.word_index      = idx;
  assign digest.last_word       = (idx == 3'd7);
  assign digest.length_overflow = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      chain     <= INIT_HASH;
      fill      <= 7'd0;
      bits      <= 64'd0;
      ovf       <= 1'b0;
      finishing <= 1'b0;
      len_block <= 1'b0;
      rnd       <= 6'd0;
      idx       <= 3'd0;
    end else begin
      case (state)
        IDLE: begin
          if (msg.valid) begin
            for (int i = 0; i < 15; i++) begin
              blk[i] <= {blk[i][23:0], blk[i+1][31:24]};
            end
            if (msg.op == OP_ABSORB) begin
              blk[15] <= {blk[15][23:0], msg.message_byte};
              bits    <= bits_sum[63:0];
              if (bits_sum[64]) begin
                ovf <= 1'b1;
              end
              if (fill == BLOCK_BYTES - 7'd1) begin
                fill  <= 7'd0;
                work  <= chain;
                rnd   <= 6'd0;
                state <= COMP;
              end else begin
                fill <= fill + 7'd1;
              end
            end else begin
              blk[15]   <= {blk[15][23:0], PAD_BYTE};
              fill      <= fill + 7'd1;
              finishing <= 1'b1;
              len_block <= (fill < LENGTH_POS);
              state     <= PAD;
            end
          end
        end
        PAD: begin
          if (fill == BLOCK_BYTES) begin
            fill  <= 7'd0;
            work  <= chain;
            rnd   <= 6'd0;
            state <= COMP;
          end else begin
            for (int i = 0; i < 15; i++) begin
              blk[i] <= {blk[i][23:0], blk[i+1][31:24]};
            end
            blk[15] <= {blk[15][23:0], pad_byte};
            fill    <= fill + 7'd1;
          end
        end
        COMP: begin
          work <= work_next;
          for (int i = 0; i < 15; i++) begin
            blk[i] <= blk[i+1];
          end
          blk[15] <= w_new;
          rnd     <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= FOLD;
          end
        end
        FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + work[i];
          end
          if (finishing && len_block) begin
            idx   <= 3'd0;
            state <= EMIT;
          end else if (finishing) begin
            len_block <= 1'b1;
            state     <= PAD;
          end else begin
            state <= IDLE;
          end
        end
        EMIT: begin
          if (digest.ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              chain     <= INIT_HASH;
              fill      <= 7'd0;
              bits      <= 64'd0;
              ovf       <= 1'b0;
              finishing <= 1'b0;
              len_block <= 1'b0;
              state     <= IDLE;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: sv/sha256_round.sv
// One SHA-256 compression round and one message schedule expansion step.
`default_nettype none
module sha256_round (
  input  wire sha256_pkg::hash_t work_in,
  input  wire sha256_pkg::word_t k,
  input  wire sha256_pkg::word_t w0,
  input  wire sha256_pkg::word_t w1,
  input  wire sha256_pkg::word_t w9,
  input  wire sha256_pkg::word_t w14,
  output sha256_pkg::hash_t work_out,
  output sha256_pkg::word_t w_new
);
  import sha256_pkg::*;

  word_t a, b, c, d, e, f, g, h;
  word_t big0, big1, ch, maj, t1, t2, s0, s1;

  always_comb begin
    a = work_in[0]; b = work_in[1]; c = work_in[2]; d = work_in[3];
    e = work_in[4]; f = work_in[5]; g = work_in[6]; h = work_in[7];
    big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    ch   = (e & f) ^ (~e & g);
    maj  = (a & b) ^ (a & c) ^ (b & c);
    t1   = h + big1 + ch + k + w0;
    t2   = big0 + maj;
    work_out[7] = g;
    work_out[6] = f;
    work_out[5] = e;
    work_out[4] = d + t1;
    work_out[3] = c;
    work_out[2] = b;
    work_out[1] = a;
    work_out[0] = t1 + t2;
    // The schedule word sixteen rounds ahead.
    s0    = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
    s1    = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ {10'd0, w14[31:10]};
    w_new = s1 + w9 + s0 + w0;
  end

endmodule
`default_nettype wire
